/* rtl/asr_pkg.sv */
package asr_pkg;

	localparam logic [3:0] MODE_TICK       = 4'd0;
	localparam logic [3:0] MODE_CHECK      = 4'd1;
	localparam logic [3:0] MODE_CONNECT    = 4'd2;
	localparam logic [3:0] MODE_DISCONNECT = 4'd3;
	localparam logic [3:0] MODE_POLL       = 4'd4;
	localparam logic [3:0] MODE_READ       = 4'd5;
	localparam logic [3:0] MODE_WRITE      = 4'd6;
	localparam logic [3:0] MODE_REGISTER   = 4'd7;
	localparam logic [3:0] MODE_DEREGISTER = 4'd8;

	localparam logic [2:0] RSP_NONE       = 3'd0;
	localparam logic [2:0] RSP_CHECK      = 3'd1;
	localparam logic [2:0] RSP_CONNECT    = 3'd2;
	localparam logic [2:0] RSP_DISCONNECT = 3'd3;
	localparam logic [2:0] RSP_POLL       = 3'd4;
	localparam logic [2:0] RSP_READ       = 3'd5;
	localparam logic [2:0] RSP_WRITE      = 3'd6;

	localparam logic [1:0] STS_ZERO = 2'd0;
	localparam logic [1:0] STS_OK   = 2'd1;
	localparam logic [1:0] STS_FAIL = 2'd2;

	localparam logic [1:0] SRC_NONE   = 2'd0;
	localparam logic [1:0] SRC_DEVID  = 2'd1;
	localparam logic [1:0] SRC_ATTR   = 2'd2;

	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_CONNECTED    = 3'd1;
	localparam logic [2:0] EV_DISCONNECTED = 3'd2;
	localparam logic [2:0] EV_READ         = 3'd3;
	localparam logic [2:0] EV_WRITTEN      = 3'd4;

	localparam logic [1:0] CFG_ENABLE      = 2'd0;
	localparam logic [1:0] CFG_DROPOUT     = 2'd1;
	localparam logic [1:0] CFG_DEVID_ADDR  = 2'd2;
	localparam logic [1:0] CFG_DEVID_LEN   = 2'd3;

	localparam logic [15:0] DROPOUT_RESET = 16'd5000;
	localparam logic [15:0] QUIET_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  perms;
		logic [15:0] length;
		logic [15:0] address;
		logic [7:0]  id;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  status;
		logic [1:0]  src;
		logic [15:0] paddr;
		logic [15:0] plen;
		logic [15:0] fill;
		logic [2:0]  ev;
		logic [7:0]  evid;
		logic        terr;
	} result_t;

	typedef struct packed {
		logic capture;
		logic scan_inc;
		logic rd_en;
		logic rd_last;
		logic hit_set;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_lookup;
		logic is_dereg;
		logic count_zero;
		logic id_match;
		logic scan_end;
		logic out_free;
	} stat_t;

endpackage

/* rtl/attribute_server_responder.sv */
// Attribute protocol responder: each beat on the slave stream (mode in tuser) yields exactly
// one result beat on the master stream (response kind in tuser). Ticks, check, connect,
// disconnect, poll and register pass from accept through a start state to a finish state
// that registers the result once the master side is free. Read, write and deregister
// search the attribute table, a memory read and compared one entry at a time up to the
// first matching id (all valid entries on a miss); a deregister hit then fetches the last
// entry. A new beat is accepted while the previous result still waits on the master side.
// Table entries are not cleared after reset; write configuration only while no beat is in flight.
module attribute_server_responder #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// attr_id, attr_address, attr_length, can_read, can_write, payload_size
	input  logic [63:0] s_tdata,
	// mode
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// response_status, payload_source, payload_address, payload_length, fill_size,
	// event_kind, event_attr_id, table_error
	output logic [63:0] m_tdata,
	// response_kind
	output logic [2:0]  m_tuser,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import asr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	asr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	asr_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

/* rtl/asr_ctrl.sv */
module asr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output asr_pkg::cmd_t  cmd,
	input  asr_pkg::stat_t stat
);
	import asr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_RD    = 6'b000100,
		ST_CMP   = 6'b001000,
		ST_LAST  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				if (stat.need_lookup && !stat.count_zero) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				priority if (stat.id_match) begin
					cmd.hit_set = 1'b1;
					state_d     = stat.is_dereg ? ST_LAST : ST_FIN;
				end else if (stat.scan_end) begin
					state_d = ST_FIN;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_LAST: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_last = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/asr_dp.sv */
module asr_dp #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  asr_pkg::cmd_t  cmd,
	output asr_pkg::stat_t stat,
	input  logic [63:0]    s_tdata,
	input  logic [3:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [63:0]    m_tdata,
	output logic [2:0]     m_tuser,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import asr_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	logic          en_q;
	logic [15:0]   dropout_q;
	logic [15:0]   devaddr_q;
	logic [7:0]    devlen_q;

	logic          connected_q, conn_d;
	logic [15:0]   quiet_q, quiet_d, quiet_inc;
	logic [CW-1:0] count_q, count_d;

	logic [3:0]    mode_q;
	logic [7:0]    id_q;
	logic [15:0]   addr_q;
	logic [15:0]   len_q;
	logic          rd_q;
	logic          wr_q;
	logic [15:0]   psize_q;

	logic [IW-1:0] scan_idx_q;
	logic [IW-1:0] hit_idx_q;
	logic          hit_q;

	entry_t        mem [TABLE_ENTRIES];
	entry_t        mem_rd_q;
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] last_idx;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;

	result_t       res;
	result_t       out_q;
	logic          out_valid_q;

	assign last_idx = count_q - CW'(1);
	assign rd_addr  = cmd.rd_last ? last_idx[IW-1:0] : scan_idx_q;

	assign stat.need_lookup = (mode_q == MODE_READ) || (mode_q == MODE_WRITE) ||
		(mode_q == MODE_DEREGISTER);
	assign stat.is_dereg    = (mode_q == MODE_DEREGISTER);
	assign stat.count_zero  = (count_q == '0);
	assign stat.id_match    = (mem_rd_q.id == id_q);
	assign stat.scan_end    = ((CW'(scan_idx_q) + CW'(1)) >= count_q);
	assign stat.out_free    = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= s_tuser;
			id_q    <= s_tdata[7:0];
			addr_q  <= s_tdata[23:8];
			len_q   <= s_tdata[39:24];
			rd_q    <= s_tdata[40];
			wr_q    <= s_tdata[41];
			psize_q <= s_tdata[57:42];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			hit_idx_q  <= '0;
			hit_q      <= 1'b0;
		end else if (cmd.capture) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
		end else begin
			if (cmd.scan_inc) begin
				scan_idx_q <= scan_idx_q + IW'(1);
			end
			if (cmd.hit_set) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	assign quiet_inc = (quiet_q != QUIET_MAX) ? quiet_q + 16'd1 : quiet_q;

	always_comb begin
		res     = '0;
		conn_d  = connected_q;
		quiet_d = quiet_q;
		count_d = count_q;
		mem_we  = 1'b0;
		mem_wa  = hit_idx_q;
		mem_wd  = mem_rd_q;
		if (en_q && (mode_q >= MODE_CHECK) && (mode_q <= MODE_WRITE)) begin
			quiet_d = '0;
		end
		unique case (mode_q)
			MODE_TICK: begin
				if (en_q) begin
					quiet_d = quiet_inc;
					if (connected_q && (quiet_inc > dropout_q)) begin
						conn_d = 1'b0;
						res.ev = EV_DISCONNECTED;
					end
				end
			end
			MODE_CHECK: begin
				if (en_q && !connected_q) begin
					res.kind  = RSP_CHECK;
					res.src   = SRC_DEVID;
					res.paddr = devaddr_q;
					res.plen  = {8'd0, devlen_q};
				end
			end
			MODE_CONNECT: begin
				if (en_q) begin
					if (!connected_q) begin
						res.ev = EV_CONNECTED;
					end
					conn_d     = 1'b1;
					res.kind   = RSP_CONNECT;
					res.status = STS_OK;
				end
			end
			MODE_DISCONNECT: begin
				if (en_q) begin
					if (connected_q) begin
						res.ev = EV_DISCONNECTED;
					end
					conn_d   = 1'b0;
					res.kind = RSP_DISCONNECT;
				end
			end
			MODE_POLL: begin
				if (en_q && connected_q) begin
					res.kind = RSP_POLL;
				end
			end
			MODE_READ: begin
				if (en_q) begin
					res.kind = RSP_READ;
					if (hit_q && mem_rd_q.perms[0]) begin
						res.status = STS_OK;
						res.src    = SRC_ATTR;
						res.paddr  = mem_rd_q.address;
						res.plen   = mem_rd_q.length;
						res.ev     = EV_READ;
						res.evid   = id_q;
					end else begin
						res.status = STS_FAIL;
					end
				end
			end
			MODE_WRITE: begin
				if (en_q) begin
					res.kind = RSP_WRITE;
					if (hit_q && mem_rd_q.perms[1]) begin
						res.status = STS_OK;
						res.src    = SRC_ATTR;
						res.paddr  = mem_rd_q.address;
						res.plen   = mem_rd_q.length;
						res.fill   = psize_q;
						res.ev     = EV_WRITTEN;
						res.evid   = id_q;
					end else begin
						res.status = STS_FAIL;
					end
				end
			end
			MODE_REGISTER: begin
				if (count_q < FULL) begin
					mem_we  = 1'b1;
					mem_wa  = count_q[IW-1:0];
					mem_wd  = '{perms: {wr_q, rd_q}, length: len_q, address: addr_q, id: id_q};
					count_d = count_q + CW'(1);
				end else begin
					res.terr = 1'b1;
				end
			end
			MODE_DEREGISTER: begin
				if (hit_q) begin
					mem_we  = 1'b1;
					count_d = last_idx;
				end
			end
			default: begin
			end
		endcase
		if (!cmd.commit) begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			dropout_q   <= DROPOUT_RESET;
			devaddr_q   <= '0;
			devlen_q    <= '0;
			connected_q <= 1'b0;
			quiet_q     <= '0;
			count_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ENABLE: begin
					en_q <= cfg_data[0];
					// disable, or a fresh start, drops the link
					if (!cfg_data[0] || !en_q) begin
						connected_q <= 1'b0;
					end
				end
				CFG_DROPOUT:    dropout_q <= cfg_data;
				CFG_DEVID_ADDR: devaddr_q <= cfg_data;
				CFG_DEVID_LEN:  devlen_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end else if (cmd.commit) begin
			connected_q <= conn_d;
			quiet_q     <= quiet_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.terr, out_q.evid, out_q.ev, out_q.fill, out_q.plen,
		out_q.paddr, out_q.src, out_q.status};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count above table size");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("result overwritten before taken");

	a_reg_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !cfg_wr_en && (mode_q == MODE_REGISTER) && (count_q < FULL))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("register did not add an entry");

	a_dereg_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !cfg_wr_en && (mode_q == MODE_DEREGISTER) && hit_q)
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("deregister did not remove an entry");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hit_set) |-> (CW'(scan_idx_q) < count_q))
		else $error("hit outside valid entries");
`endif

endmodule

/* tb/asr_response_checker.sv */
`timescale 1ns / 1ps

module asr_response_checker #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          responses_due
);
	import asr_pkg::*;

	logic        enabled;
	logic [15:0] dropout;
	logic [15:0] devid_addr;
	logic [7:0]  devid_len;
	logic        connected;
	logic [15:0] quiet;
	int          entry_count;
	entry_t      attr_tab [TABLE_ENTRIES];
	result_t     pending_responses [$];
	result_t     next_resp;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
				   input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", what, got, want));
	endtask

	function automatic bit find_entry(input logic [7:0] id, output int where);
		where = 0;
		for (int i = 0; i < entry_count; i++) begin
			if (attr_tab[i].id == id) begin
				where = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
		case (idx)
			CFG_ENABLE: begin
				// disable, or a fresh start, drops the link silently
				if (!val[0] || !enabled)
					connected = 1'b0;
				enabled = val[0];
			end
			CFG_DROPOUT:    dropout = val;
			CFG_DEVID_ADDR: devid_addr = val;
			CFG_DEVID_LEN:  devid_len = val[7:0];
			default: ;
		endcase
	endtask

	task automatic serve_item(input logic [3:0] mode, input logic [63:0] d,
				  output result_t r);
		logic [7:0]  id;
		logic [15:0] addr;
		logic [15:0] len;
		logic        rd;
		logic        wr;
		logic [15:0] psize;
		int          idx;
		id    = d[7:0];
		addr  = d[23:8];
		len   = d[39:24];
		rd    = d[40];
		wr    = d[41];
		psize = d[57:42];
		r     = '0;
		if (mode >= MODE_CHECK && mode <= MODE_WRITE && enabled)
			quiet = '0;
		case (mode)
			MODE_TICK: begin
				if (enabled) begin
					if (quiet != QUIET_MAX)
						quiet++;
					if (connected && quiet > dropout) begin
						connected = 1'b0;
						r.ev = EV_DISCONNECTED;
					end
				end
			end
			MODE_CHECK: begin
				if (enabled && !connected) begin
					r.kind   = RSP_CHECK;
					r.status = STS_ZERO;
					r.src    = SRC_DEVID;
					r.paddr  = devid_addr;
					r.plen   = {8'd0, devid_len};
				end
			end
			MODE_CONNECT: begin
				if (enabled) begin
					if (!connected) begin
						r.ev = EV_CONNECTED;
						connected = 1'b1;
					end
					r.kind   = RSP_CONNECT;
					r.status = STS_OK;
				end
			end
			MODE_DISCONNECT: begin
				if (enabled) begin
					if (connected) begin
						r.ev = EV_DISCONNECTED;
						connected = 1'b0;
					end
					r.kind   = RSP_DISCONNECT;
					r.status = STS_ZERO;
				end
			end
			MODE_POLL: begin
				if (enabled && connected) begin
					r.kind   = RSP_POLL;
					r.status = STS_ZERO;
				end
			end
			MODE_READ: begin
				if (enabled) begin
					r.kind = RSP_READ;
					if (find_entry(id, idx) && attr_tab[idx].perms[0]) begin
						r.status = STS_OK;
						r.src    = SRC_ATTR;
						r.paddr  = attr_tab[idx].address;
						r.plen   = attr_tab[idx].length;
						r.ev     = EV_READ;
						r.evid   = id;
					end else begin
						r.status = STS_FAIL;
					end
				end
			end
			MODE_WRITE: begin
				if (enabled) begin
					r.kind = RSP_WRITE;
					if (find_entry(id, idx) && attr_tab[idx].perms[1]) begin
						r.status = STS_OK;
						r.src    = SRC_ATTR;
						r.paddr  = attr_tab[idx].address;
						r.plen   = attr_tab[idx].length;
						r.fill   = psize;
						r.ev     = EV_WRITTEN;
						r.evid   = id;
					end else begin
						r.status = STS_FAIL;
					end
				end
			end
			MODE_REGISTER: begin
				if (entry_count < TABLE_ENTRIES) begin
					attr_tab[entry_count] = '{perms: {wr, rd}, length: len,
								  address: addr, id: id};
					entry_count++;
				end else begin
					r.terr = 1'b1;
				end
			end
			MODE_DEREGISTER: begin
				// freed slot takes the last entry
				if (find_entry(id, idx)) begin
					attr_tab[idx] = attr_tab[entry_count - 1];
					entry_count--;
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_response();
		result_t want;
		if (pending_responses.size() == 0) begin
			report_mismatch("result beat with nothing expected");
			return;
		end
		want = pending_responses.pop_front();
		check_field("response_kind",   m_tuser,        want.kind);
		check_field("response_status", m_tdata[1:0],   want.status);
		check_field("payload_source",  m_tdata[3:2],   want.src);
		check_field("payload_address", m_tdata[19:4],  want.paddr);
		check_field("payload_length",  m_tdata[35:20], want.plen);
		check_field("fill_size",       m_tdata[51:36], want.fill);
		check_field("event_kind",      m_tdata[54:52], want.ev);
		check_field("event_attr_id",   m_tdata[62:55], want.evid);
		check_field("table_error",     m_tdata[63],    want.terr);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled     = 1'b0;
			dropout     = DROPOUT_RESET;
			devid_addr  = '0;
			devid_len   = '0;
			connected   = 1'b0;
			quiet       = '0;
			entry_count = 0;
			pending_responses.delete();
			mismatch_count = 0;
			responses_due <= 0;
		end else begin
			if (cfg_wr_en)
				write_register(cfg_index, cfg_data);
			if (m_tvalid && m_tready)
				compare_response();
			if (s_tvalid && s_tready) begin
				serve_item(s_tuser, s_tdata, next_resp);
				pending_responses.push_back(next_resp);
			end
			responses_due <= pending_responses.size();
		end
	end

endmodule

/* tb/attribute_server_responder_tb.sv */
`timescale 1ns / 1ps

module attribute_server_responder_tb;
	import asr_pkg::*;

	localparam int ENTRIES     = 16;
	localparam int STALL_LIMIT = 4000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic [3:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	int mismatch_count;
	int responses_due;
	int stall_cycles = 0;
	bit calm = 1'b0;

	always #4 clk = ~clk;

	attribute_server_responder #(.TABLE_ENTRIES(ENTRIES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	asr_response_checker #(.TABLE_ENTRIES(ENTRIES)) u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .responses_due(responses_due)
	);

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= 29);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_beat(input logic [3:0] mode, input logic [7:0] id,
				 input logic [15:0] addr, input logic [15:0] len,
				 input logic rd, input logic wr, input logic [15:0] psize);
		while (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, psize, wr, rd, len, addr, id};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_req(input logic [3:0] mode, input logic [7:0] id);
		send_beat(mode, id, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
			  16'($urandom));
	endtask

	task automatic send_random();
		int          r;
		logic [3:0]  mode;
		logic [7:0]  id;
		r = $urandom_range(99);
		if (r < 20)      mode = MODE_TICK;
		else if (r < 27) mode = MODE_CHECK;
		else if (r < 37) mode = MODE_CONNECT;
		else if (r < 42) mode = MODE_DISCONNECT;
		else if (r < 50) mode = MODE_POLL;
		else if (r < 64) mode = MODE_READ;
		else if (r < 76) mode = MODE_WRITE;
		else if (r < 87) mode = MODE_REGISTER;
		else if (r < 98) mode = MODE_DEREGISTER;
		else             mode = 4'($urandom_range(9, 15));
		case ($urandom_range(9))
			0:       id = 8'hFF;
			1:       id = 8'($urandom);
			default: id = 8'($urandom_range(7));
		endcase
		send_req(mode, id);
	endtask

	// stop sending and wait until every response has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (responses_due != 0) @(posedge clk);
	endtask

	// caller lowers cfg_wr_en after the last write of a group
	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] en, input logic [15:0] drop,
				  input logic [15:0] daddr, input logic [15:0] dlen);
		cfg_write(CFG_ENABLE, en);
		cfg_write(CFG_DROPOUT, drop);
		cfg_write(CFG_DEVID_ADDR, daddr);
		cfg_write(CFG_DEVID_LEN, dlen);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [15:0] drop;
		logic [15:0] daddr;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// server disabled after reset: requests come back empty, table still works
		send_req(MODE_TICK, 8'h00);
		send_req(MODE_CHECK, 8'h00);
		send_req(MODE_CONNECT, 8'h00);
		send_req(MODE_READ, 8'h01);
		send_beat(MODE_REGISTER, 8'h01, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000);
		send_beat(MODE_REGISTER, 8'hFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'hFFFF);
		send_beat(MODE_REGISTER, 8'h01, 16'h1234, 16'h0005, 1'b1, 1'b1, 16'h0000);
		drain();
		set_config(16'h0001, 16'd2, 16'hFFFF, 16'h00FF);

		send_req(MODE_CHECK, 8'h00);
		send_req(MODE_CONNECT, 8'h00);
		send_req(MODE_CONNECT, 8'h00);
		send_req(MODE_POLL, 8'h00);
		send_req(MODE_CHECK, 8'h00);
		send_req(MODE_READ, 8'h01);
		send_req(MODE_READ, 8'h7E);
		send_req(MODE_WRITE, 8'h01);
		send_beat(MODE_WRITE, 8'hFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'hFFFF);
		send_req(MODE_READ, 8'hFF);
		repeat (3) send_req(MODE_TICK, 8'h00);
		send_req(MODE_POLL, 8'h00);
		send_req(MODE_DISCONNECT, 8'h00);
		send_req(MODE_CONNECT, 8'h00);
		send_req(MODE_DISCONNECT, 8'h00);
		send_req(MODE_DEREGISTER, 8'h01);
		send_req(MODE_READ, 8'h01);
		send_req(MODE_DEREGISTER, 8'h42);
		send_req(4'd9, 8'h00);
		send_beat(4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);

		// fill the table, then one register too many
		for (int i = 0; i < ENTRIES - 1; i++)
			send_req(MODE_REGISTER, 8'(i + 16));
		send_req(MODE_DEREGISTER, 8'h00);
		for (int i = 0; i < ENTRIES - 1; i++)
			send_req(MODE_DEREGISTER, 8'(i + 16));

		// enable 1 -> 1 keeps the link, 0 -> 1 drops it
		send_req(MODE_CONNECT, 8'h00);
		drain();
		cfg_write(CFG_ENABLE, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		send_req(MODE_POLL, 8'h00);
		drain();
		cfg_write(CFG_ENABLE, 16'hFFFE);
		cfg_write(CFG_ENABLE, 16'h0001);
		cfg_wr_en <= 1'b0;
		send_req(MODE_POLL, 8'h00);

		// no drop while quiet stays under the limit, then drop right after lowering it
		drain();
		set_config(16'h0001, 16'd50, 16'h0000, 16'h0000);
		calm = 1'b1;
		send_req(MODE_CONNECT, 8'h00);
		repeat (40) send_req(MODE_TICK, 8'h00);
		drain();
		cfg_write(CFG_DROPOUT, 16'd20);
		cfg_wr_en <= 1'b0;
		send_req(MODE_TICK, 8'h00);
		send_req(MODE_POLL, 8'h00);
		calm = 1'b0;

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case ($urandom_range(4))
				0:       drop = 16'd1;
				1:       drop = 16'hFFFF;
				2:       drop = 16'($urandom_range(1, 8));
				3:       drop = 16'($urandom_range(1, 40));
				default: drop = 16'($urandom_range(1, 65535));
			endcase
			case (phase % 3)
				0:       daddr = 16'h0000;
				1:       daddr = 16'hFFFF;
				default: daddr = 16'($urandom);
			endcase
			set_config({15'($urandom), phase != 3}, drop, daddr, 16'($urandom));
			calm = (phase == 5);
			for (int n = 0; n < 170; n++) begin
				send_random();
				if ($urandom_range(99) == 0)
					drain();
			end
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && responses_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/asr_pkg.sv
rtl/asr_ctrl.sv
rtl/asr_dp.sv
rtl/attribute_server_responder.sv
tb/asr_response_checker.sv
tb/attribute_server_responder_tb.sv
